[rtl/core/mva_pkg.sv]
// Shared constants, codes, types and modular helpers for the modular vector ALU.
package mva_pkg;

  localparam int unsigned DATA_BITS     = 64;
  localparam int unsigned CMD_BITS      = 3;
  localparam int unsigned REG_IDX_BITS  = 3;
  localparam int unsigned WORD_BITS_DEF = 64;

  typedef logic [DATA_BITS-1:0]    data_t;
  typedef logic [CMD_BITS-1:0]     cmd_t;
  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  localparam cmd_t CMD_ADD   = 3'd0;
  localparam cmd_t CMD_SUB   = 3'd1;
  localparam cmd_t CMD_MUL   = 3'd2;
  localparam cmd_t CMD_NEG   = 3'd3;
  localparam cmd_t CMD_SCALE = 3'd4;
  localparam cmd_t CMD_FWD   = 3'd5;
  localparam cmd_t CMD_INV   = 3'd6;

  localparam reg_idx_t REG_MODULUS     = 3'd0;
  localparam reg_idx_t REG_UNIT_I      = 3'd1;
  localparam reg_idx_t REG_UNIT_I_INV  = 3'd2;
  localparam reg_idx_t REG_INVERSE_TWO = 3'd3;
  localparam reg_idx_t REG_SCALE       = 3'd4;

  // x, y below q
  function automatic data_t mod_add(data_t x, data_t y, data_t q);
    data_t room;
    room = q - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  // x, y below q
  function automatic data_t mod_sub(data_t x, data_t y, data_t q);
    return (x >= y) ? (x - y) : (x + (q - y));
  endfunction

endpackage

[rtl/core/mva_in_if.sv]
// Input channel of the modular vector ALU: command word with two operands.
interface mva_in_if;
  import mva_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  data_t operand_a;
  data_t operand_b;
  logic  is_last;

  modport source (output valid, command, operand_a, operand_b, is_last, input ready);
  modport sink   (input valid, command, operand_a, operand_b, is_last, output ready);
endinterface

[rtl/core/mva_out_if.sv]
// Output channel of the modular vector ALU: one result word per input word.
interface mva_out_if;
  import mva_pkg::*;

  logic  valid;
  logic  ready;
  data_t result_first;
  data_t result_second;
  logic  last_out;

  modport source (output valid, result_first, result_second, last_out, input ready);
  modport sink   (input valid, result_first, result_second, last_out, output ready);
endinterface

[rtl/core/mva_mulmod.sv]
// Pipelined shift-and-add modular multiplier, one multiplier bit per stage.
module mva_mulmod #(
  parameter int unsigned WORD_BITS = mva_pkg::WORD_BITS_DEF,
  parameter int unsigned SIDE_BITS = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic [WORD_BITS-1:0] q_i,
  input  logic [WORD_BITS-1:0] x_i,
  input  logic [WORD_BITS-1:0] y_i,
  input  logic [SIDE_BITS-1:0] side_i,
  output logic                 vld_o,
  output logic [WORD_BITS-1:0] r_o,
  output logic [SIDE_BITS-1:0] side_o
);
  import mva_pkg::*;

  localparam int unsigned W = WORD_BITS;

  logic                 vld_q  [W];
  logic [W-1:0]         r_q    [W];
  logic [W-1:0]         x_q    [W];
  logic [W-1:0]         y_q    [W];
  logic [SIDE_BITS-1:0] side_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic                 vin;
    logic [W-1:0]         r_in;
    logic [W-1:0]         x_in;
    logic [W-1:0]         y_in;
    logic [SIDE_BITS-1:0] s_in;
    logic [W-1:0]         dbl;
    logic [W-1:0]         r_d;

    if (k == 0) begin : g_head
      assign vin  = vld_i;
      assign r_in = '0;
      assign x_in = x_i;
      assign y_in = y_i;
      assign s_in = side_i;
    end else begin : g_body
      assign vin  = vld_q[k-1];
      assign r_in = r_q[k-1];
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign s_in = side_q[k-1];
    end

    // double, then add x when this multiplier bit is set
    always_comb begin
      dbl = W'(mod_add(DATA_BITS'(r_in), DATA_BITS'(r_in), DATA_BITS'(q_i)));
      r_d = y_in[W-1-k] ? W'(mod_add(DATA_BITS'(dbl), DATA_BITS'(x_in), DATA_BITS'(q_i)))
                        : dbl;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= r_d;
        x_q[k]    <= x_in;
        y_q[k]    <= y_in;
        side_q[k] <= s_in;
      end
    end
  end

  assign vld_o  = vld_q[W-1];
  assign r_o    = r_q[W-1];
  assign side_o = side_q[W-1];

endmodule

[rtl/core/modular_vector_alu.sv]
// Modular vector ALU: throughput one word per cycle unless the output stalls. The
// shift-and-add multiplier pipelines take one bit per stage, so depth follows WORD_BITS:
// operand reduction, first product, second product. A one-word input skid takes a word
// while a finished result waits at the output.
// Reset: q=3, I=1, I^-1=1, inverse_two=2, scale=1; pipeline and skid valids clear.
module modular_vector_alu #(
  parameter int unsigned WORD_BITS = mva_pkg::WORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  mva_pkg::reg_idx_t cfg_index_i,
  input  mva_pkg::data_t    cfg_wdata_i,
  mva_in_if.sink            in_if,
  mva_out_if.source         out_if
);
  import mva_pkg::*;

  localparam int unsigned W      = WORD_BITS;
  localparam int unsigned SIDE_M = CMD_BITS + 1 + 4 * W;

  typedef logic [W-1:0] word_t;

  function automatic word_t wadd(word_t x, word_t y, word_t q);
    return W'(mod_add(DATA_BITS'(x), DATA_BITS'(y), DATA_BITS'(q)));
  endfunction

  function automatic word_t wsub(word_t x, word_t y, word_t q);
    return W'(mod_sub(DATA_BITS'(x), DATA_BITS'(y), DATA_BITS'(q)));
  endfunction

  // ---------------------------------------------------------------- config
  word_t modulus_q, unit_i_q, unit_i_inv_q, inverse_two_q, scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q     <= W'(3);
      unit_i_q      <= W'(1);
      unit_i_inv_q  <= W'(1);
      inverse_two_q <= W'(2);
      scale_q       <= W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODULUS:     modulus_q     <= cfg_wdata_i[W-1:0];
        REG_UNIT_I:      unit_i_q      <= cfg_wdata_i[W-1:0];
        REG_UNIT_I_INV:  unit_i_inv_q  <= cfg_wdata_i[W-1:0];
        REG_INVERSE_TWO: inverse_two_q <= cfg_wdata_i[W-1:0];
        REG_SCALE:       scale_q       <= cfg_wdata_i[W-1:0];
        default: ;
      endcase
    end
  end

  // One stall signal for every stage: advance whenever the output slot is free.
  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || out_if.ready;

  // ---------------------------------------------------------------- input skid
  logic  skid_vld_q;
  cmd_t  skid_cmd_q;
  word_t skid_a_q, skid_b_q;
  logic  skid_last_q;
  logic  in_acc;

  assign in_if.ready = !skid_vld_q;
  assign in_acc      = in_if.valid && !skid_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= 1'b0;
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  // hold the word here while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (!en && in_acc) begin
      skid_cmd_q  <= in_if.command;
      skid_a_q    <= in_if.operand_a[W-1:0];
      skid_b_q    <= in_if.operand_b[W-1:0];
      skid_last_q <= in_if.is_last;
    end
  end

  logic  head_vld;
  cmd_t  head_cmd;
  word_t head_a, head_b;
  logic  head_last;

  always_comb begin
    head_vld  = skid_vld_q || in_acc;
    head_cmd  = skid_vld_q ? skid_cmd_q  : in_if.command;
    head_a    = skid_vld_q ? skid_a_q    : in_if.operand_a[W-1:0];
    head_b    = skid_vld_q ? skid_b_q    : in_if.operand_b[W-1:0];
    head_last = skid_vld_q ? skid_last_q : in_if.is_last;
  end

  // ---------------------------------------------------------------- reduction
  // Reduce a and b mod q as products with one; q of one gives a zero multiplicand.
  word_t one_w;
  assign one_w = (modulus_q == W'(1)) ? '0 : W'(1);

  logic  red_vld_a, red_vld_b;
  word_t red_a, red_b;
  cmd_t  red_cmd;
  logic  red_last;

  mva_mulmod #(.WORD_BITS(W), .SIDE_BITS(CMD_BITS)) u_red_a (
    .clk_i, .rst_ni, .en_i(en), .vld_i(head_vld), .q_i(modulus_q),
    .x_i(one_w), .y_i(head_a), .side_i(head_cmd),
    .vld_o(red_vld_a), .r_o(red_a), .side_o(red_cmd)
  );

  mva_mulmod #(.WORD_BITS(W), .SIDE_BITS(1)) u_red_b (
    .clk_i, .rst_ni, .en_i(en), .vld_i(head_vld), .q_i(modulus_q),
    .x_i(one_w), .y_i(head_b), .side_i(head_last),
    .vld_o(red_vld_b), .r_o(red_b), .side_o(red_last)
  );

  // ---------------------------------------------------------------- prep stage
  logic  p1_vld_q;
  cmd_t  p1_cmd_q;
  logic  p1_last_q;
  word_t p1_a_q, p1_sum_q, p1_diff_q, p1_neg_q, p1_mx_q, p1_my_q;
  word_t sum_d, diff_d, neg_d, mx_d, my_d;

  always_comb begin
    sum_d  = wadd(red_a, red_b, modulus_q);
    diff_d = wsub(red_a, red_b, modulus_q);
    neg_d  = wsub('0, red_a, modulus_q);
    case (red_cmd)
      CMD_MUL: begin
        mx_d = red_a;
        my_d = red_b;
      end
      CMD_SCALE: begin
        mx_d = red_a;
        my_d = scale_q;
      end
      CMD_FWD: begin
        mx_d = red_b;
        my_d = unit_i_q;
      end
      CMD_INV: begin
        mx_d = diff_d;
        my_d = unit_i_inv_q;
      end
      default: begin
        mx_d = '0;
        my_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else if (en) begin
      p1_vld_q <= red_vld_a && red_vld_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_cmd_q  <= red_cmd;
      p1_last_q <= red_last;
      p1_a_q    <= red_a;
      p1_sum_q  <= sum_d;
      p1_diff_q <= diff_d;
      p1_neg_q  <= neg_d;
      p1_mx_q   <= mx_d;
      p1_my_q   <= my_d;
    end
  end

  // ---------------------------------------------------------------- first product
  // The scanned multiplier may be any pattern: shift-and-add still lands on x*y mod q.
  logic              m1_vld;
  word_t             m1_p;
  logic [SIDE_M-1:0] m1_side;

  mva_mulmod #(.WORD_BITS(W), .SIDE_BITS(SIDE_M)) u_mul1 (
    .clk_i, .rst_ni, .en_i(en), .vld_i(p1_vld_q), .q_i(modulus_q),
    .x_i(p1_mx_q), .y_i(p1_my_q),
    .side_i({p1_cmd_q, p1_last_q, p1_a_q, p1_sum_q, p1_diff_q, p1_neg_q}),
    .vld_o(m1_vld), .r_o(m1_p), .side_o(m1_side)
  );

  word_t m1_sum;
  assign m1_sum = m1_side[2*W +: W];

  // ---------------------------------------------------------------- second product
  // Lane A halves the sum, lane B halves the first product; only inverse uses them.
  logic              m2_vld_a, m2_vld_b;
  word_t             m2_ra, m2_rb, m2_p;
  logic [SIDE_M-1:0] m2_side;

  mva_mulmod #(.WORD_BITS(W), .SIDE_BITS(SIDE_M)) u_mul2_a (
    .clk_i, .rst_ni, .en_i(en), .vld_i(m1_vld), .q_i(modulus_q),
    .x_i(m1_sum), .y_i(inverse_two_q), .side_i(m1_side),
    .vld_o(m2_vld_a), .r_o(m2_ra), .side_o(m2_side)
  );

  mva_mulmod #(.WORD_BITS(W), .SIDE_BITS(W)) u_mul2_b (
    .clk_i, .rst_ni, .en_i(en), .vld_i(m1_vld), .q_i(modulus_q),
    .x_i(m1_p), .y_i(inverse_two_q), .side_i(m1_p),
    .vld_o(m2_vld_b), .r_o(m2_rb), .side_o(m2_p)
  );

  cmd_t  f_cmd;
  logic  f_last;
  word_t f_a, f_sum, f_diff, f_neg;

  assign {f_cmd, f_last, f_a, f_sum, f_diff, f_neg} = m2_side;

  // ---------------------------------------------------------------- result select
  word_t first_d, second_d;

  always_comb begin
    first_d  = '0;
    second_d = '0;
    case (f_cmd)
      CMD_ADD:   first_d = f_sum;
      CMD_SUB:   first_d = f_diff;
      CMD_MUL:   first_d = m2_p;
      CMD_NEG:   first_d = f_neg;
      CMD_SCALE: first_d = m2_p;
      CMD_FWD: begin
        first_d  = wadd(f_a, m2_p, modulus_q);
        second_d = wsub(f_a, m2_p, modulus_q);
      end
      CMD_INV: begin
        first_d  = m2_ra;
        second_d = m2_rb;
      end
      default: ;
    endcase
    // zero modulus: drop every result to zero
    if (modulus_q == '0) begin
      first_d  = '0;
      second_d = '0;
    end
  end

  word_t out_first_q, out_second_q;
  logic  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= m2_vld_a && m2_vld_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_first_q  <= first_d;
      out_second_q <= second_d;
      out_last_q   <= f_last;
    end
  end

  assign out_if.valid         = out_vld_q;
  assign out_if.result_first  = DATA_BITS'(out_first_q);
  assign out_if.result_second = DATA_BITS'(out_second_q);
  assign out_if.last_out      = out_last_q;

  // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(!en))
    else $error("skid filled while pipeline advanced");

  a_red_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_vld_a == red_vld_b)
    else $error("reduction lanes out of step");

  a_mul2_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m2_vld_a == m2_vld_b)
    else $error("second product lanes out of step");

  a_stall_holds_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(out_first_q) && $stable(out_second_q))
    else $error("output changed during stall");
`endif

endmodule

[test/tb_top.sv]
// Testbench for the modular vector ALU: directed table, then random words checked by a predictor.
module tb_top;
  import mva_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DRAIN_CYCLES = 3 * 64 + 20;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam data_t       MAX_WORD     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam data_t       PRIME_61     = 64'h1FFF_FFFF_FFFF_FFFF;  // 2^61-1
  localparam data_t       PRIME_BIG    = 64'hFFFF_FFFF_FFFF_FFC5;  // 2^64-59
  localparam cmd_t        CMD_UNUSED   = 3'd7;

  typedef struct packed {
    data_t first;
    data_t second;
    logic  last;
  } alu_result_t;

  typedef struct {
    cmd_t  cmd;
    data_t a;
    data_t b;
    logic  last;
    logic  known;     // result typed in below, not taken from the predictor
    data_t r1;
    data_t r2;
  } stim_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    cfg_we_i;
  reg_idx_t cfg_index_i;
  data_t   cfg_wdata_i;

  mva_in_if  in_ch ();
  mva_out_if out_ch ();

  modular_vector_alu dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch.sink),
    .out_if      (out_ch.source)
  );

  // Shadow copy of the configuration registers.
  data_t sh_q, sh_i, sh_ii, sh_half, sh_scale;

  alu_result_t pending_results[$];
  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned send_idle_pct, recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // 128-bit wide arithmetic keeps the predictor independent of the RTL helpers.
  function automatic data_t mulmod(data_t x, data_t y, data_t q);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return data_t'(p % {64'd0, q});
  endfunction

  function automatic data_t addmod(data_t x, data_t y, data_t q);
    logic [64:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, q}) s = s - {1'b0, q};
    return s[63:0];
  endfunction

  function automatic data_t submod(data_t x, data_t y, data_t q);
    return (x >= y) ? x - y : x + (q - y);
  endfunction

  function automatic alu_result_t predict_alu(cmd_t cmd, data_t a_in, data_t b_in, logic last);
    alu_result_t r;
    data_t a, b, t;
    r = '{first: '0, second: '0, last: last};
    if (sh_q != 0) begin
      a = a_in % sh_q;
      b = b_in % sh_q;
      case (cmd)
        CMD_ADD:   r.first = addmod(a, b, sh_q);
        CMD_SUB:   r.first = submod(a, b, sh_q);
        CMD_MUL:   r.first = mulmod(a, b, sh_q);
        CMD_NEG:   r.first = submod(0, a, sh_q);
        CMD_SCALE: r.first = mulmod(a, sh_scale % sh_q, sh_q);
        CMD_FWD: begin
          t = mulmod(b, sh_i % sh_q, sh_q);
          r.first  = addmod(a, t, sh_q);
          r.second = submod(a, t, sh_q);
        end
        CMD_INV: begin
          r.first  = mulmod(addmod(a, b, sh_q), sh_half % sh_q, sh_q);
          r.second = mulmod(mulmod(submod(a, b, sh_q), sh_ii % sh_q, sh_q),
                            sh_half % sh_q, sh_q);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, data_t val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_MODULUS:     sh_q     = val;
      REG_UNIT_I:      sh_i     = val;
      REG_UNIT_I_INV:  sh_ii    = val;
      REG_INVERSE_TWO: sh_half  = val;
      REG_SCALE:       sh_scale = val;
      default: ;
    endcase
  endtask

  // Set all five registers; call only with the pipeline empty.
  task automatic load_field(data_t q, data_t i, data_t ii, data_t h, data_t s);
    write_reg(REG_MODULUS, q);
    write_reg(REG_UNIT_I, i);
    write_reg(REG_UNIT_I_INV, ii);
    write_reg(REG_INVERSE_TWO, h);
    write_reg(REG_SCALE, s);
  endtask

  // Drive one word and hold it until the ALU takes it; expectation queued at accept.
  task automatic send_word(cmd_t cmd, data_t a, data_t b, logic last, logic known,
                           data_t r1, data_t r2);
    alu_result_t exp_r;
    while (($urandom % 100) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.command   <= cmd;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    in_ch.is_last   <= last;
    do @(posedge clk_i); while (!in_ch.ready);
    exp_r = known ? alu_result_t'{first: r1, second: r2, last: last}
                  : predict_alu(cmd, a, b, last);
    pending_results.push_back(exp_r);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Operand pick: biased toward edges and toward values below q.
  function automatic data_t pick_operand();
    data_t v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return (sh_q == 0) ? 0 : sh_q - 1;
      2:       return MAX_WORD;
      3:       return v;
      default: return (sh_q == 0) ? v : v % sh_q;
    endcase
  endfunction

  task automatic random_burst(int unsigned n);
    cmd_t c;
    for (int unsigned k = 0; k < n; k++) begin
      c = cmd_t'($urandom_range(0, 20) == 0 ? CMD_UNUSED : $urandom_range(0, 6));
      send_word(c, pick_operand(), pick_operand(), 1'($urandom), 1'b0, 0, 0);
    end
  endtask

  // Checker and receiver stalls.
  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.result_first !== exp_r.first) begin
          $error("result_first: expected %h, got %h", exp_r.first, out_ch.result_first);
          fail_count++;
        end
        if (out_ch.result_second !== exp_r.second) begin
          $error("result_second: expected %h, got %h", exp_r.second, out_ch.result_second);
          fail_count++;
        end
        if (out_ch.last_out !== exp_r.last) begin
          $error("last_out: expected %b, got %b", exp_r.last, out_ch.last_out);
          fail_count++;
        end
      end
    end
    out_ch.ready <= (($urandom % 100) >= recv_idle_pct);
  end

  // Watchdog: count cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  stim_row_t dir_rows[$];

  initial begin
    fail_count    = 0;
    idle_cycles   = 0;
    send_idle_pct = 26;
    recv_idle_pct = 79;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = '0;
    cfg_wdata_i   = '0;
    in_ch.valid   = 1'b0;
    in_ch.command = CMD_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    in_ch.is_last = 1'b0;
    out_ch.ready  = 1'b0;
    sh_q = 3; sh_i = 1; sh_ii = 1; sh_half = 2; sh_scale = 1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at reset values (q=3) with known answers, then predictor rows.
    dir_rows = '{
      '{CMD_ADD,    2, 2, 0, 1, 1, 0},
      '{CMD_SUB,    0, 1, 1, 1, 2, 0},
      '{CMD_MUL,    2, 2, 0, 1, 1, 0},
      '{CMD_NEG,    1, 0, 1, 1, 2, 0},
      '{CMD_NEG,    0, 0, 0, 1, 0, 0},
      '{CMD_SCALE,  2, 9, 0, 1, 2, 0},
      '{CMD_ADD,    MAX_WORD, MAX_WORD, 1, 1, 0, 0},
      '{CMD_FWD,    1, 1, 0, 1, 2, 0},
      '{CMD_INV,    1, 2, 1, 1, 0, 1},
      '{CMD_UNUSED, 2, 2, 1, 1, 0, 0},
      '{CMD_MUL,    MAX_WORD, 64'h7, 0, 0, 0, 0},
      '{CMD_FWD,    MAX_WORD, 64'h5, 1, 0, 0, 0}
    };
    foreach (dir_rows[k])
      send_word(dir_rows[k].cmd, dir_rows[k].a, dir_rows[k].b, dir_rows[k].last,
                dir_rows[k].known, dir_rows[k].r1, dir_rows[k].r2);
    wait_drained();

    // Zero modulus: everything zero, marker passes.
    load_field(0, MAX_WORD, MAX_WORD, MAX_WORD, MAX_WORD);
    send_word(CMD_MUL, MAX_WORD, MAX_WORD, 1, 1, 0, 0);
    send_word(CMD_FWD, 5, 7, 0, 1, 0, 0);
    wait_drained();
    // Modulus one: every residue zero.
    write_reg(REG_MODULUS, 1);
    send_word(CMD_INV, MAX_WORD, 3, 1, 1, 0, 0);
    send_word(CMD_NEG, 7, 0, 0, 1, 0, 0);
    wait_drained();
    // Out-of-range index is ignored by the ALU and by the shadow.
    write_reg(reg_idx_t'(7), 64'd5);
    write_reg(reg_idx_t'(5), 64'd5);

    // Random phases over several fields; 13 is prime with I=5 (5^2 = -1 mod 13).
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin send_idle_pct = 79; recv_idle_pct = 26; end
      if (phase == 2) begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      load_field(13, 5, 8, 7, 4);
      random_burst(120);
      wait_drained();
      load_field(PRIME_61, 64'h1234_5678_9ABC, {$urandom, $urandom}, 64'h1000_0000_0000_0000,
                 MAX_WORD);
      random_burst(180);
      wait_drained();
      // Registers above q exercise reduction before use.
      load_field(PRIME_BIG, MAX_WORD, {$urandom, $urandom}, 64'h7FFF_FFFF_FFFF_FFE3,
                 {$urandom, $urandom});
      random_burst(170);
      wait_drained();
      load_field(3, 1, 1, 2, 1);
      random_burst(70);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/mva_pkg.sv
rtl/core/mva_in_if.sv
rtl/core/mva_out_if.sv
rtl/core/mva_mulmod.sv
rtl/core/modular_vector_alu.sv
test/tb_top.sv
